@@ sv/srdm_pkg.sv @@
// shared types and constants for the sequence reorder / dedup / merge block
// no dependencies; imported by srdm_alu, sequence_reorder_dedup_merge_top and the testbench files
`timescale 1ns / 1ps

package srdm_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int ID_W   = 32;
    localparam int UT_W   = 32;
    localparam int SEQ_W  = 64;
    localparam int TS_W   = 64;
    localparam int DATA_W = ID_W + UT_W + SEQ_W + TS_W;

    localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // one buffered record, sequence is implied by the slot position
    typedef struct packed {
        logic [TS_W-1:0] timestamp;
        logic [UT_W-1:0] upd_kind;
        logic [ID_W-1:0] news_id;
    } slot_t;

    // shared subtractor result
    typedef struct packed {
        logic             no_borrow;
        logic [SEQ_W-1:0] diff;
    } alu_res_t;

endpackage

@@ sv/srdm_alu.sv @@
// shared 64-bit subtract unit: result = a - b, with carry as no-borrow flag
// depends on srdm_pkg
`timescale 1ns / 1ps

module srdm_alu
(
    input  logic [srdm_pkg::SEQ_W-1:0] op_a,
    input  logic [srdm_pkg::SEQ_W-1:0] op_b,
    output srdm_pkg::alu_res_t         res
);
    import srdm_pkg::*;

    logic [SEQ_W:0] sum;

    // a + ~b + 1; with b all ones this gives a + 1
    assign sum           = {1'b0, op_a} + {1'b0, ~op_b} + {{SEQ_W{1'b0}}, 1'b1};
    assign res.diff      = sum[SEQ_W-1:0];
    assign res.no_borrow = sum[SEQ_W];

endmodule

@@ sv/sequence_reorder_dedup_merge_top.sv @@
// two-feed sequence arbiter: reorder window, duplicate drop, in-order release
// depends on srdm_pkg and srdm_alu
//
//  channel   dir  handshake         payload
//  s_axis    in   tvalid / tready   tdata: news_id, upd_kind, sequence_req, timestamp
//  m_axis    out  tvalid / tready   tdata: out_news_id, out_upd_kind, out_sequence,
//                                   out_timestamp; tuser: status; tlast: last
//
//  one request at a time: accept, range check, slot store, then a slot read and an
//  emit per released record; ignored and rejected requests end before any slot read
//  the single 64-bit subtractor in srdm_alu does both the window check and the
//  sequence increment, and the slot memory has one read port
//  rst_n is asynchronous active low and clears the window valid bits at once
//  the output register holds a result until taken; a stall on m_axis stalls draining
`timescale 1ns / 1ps

module sequence_reorder_dedup_merge_top
(
    input  logic                        clk,
    input  logic                        rst_n,

    // news_id [31:0], upd_kind [63:32], sequence_req [127:64], timestamp [191:128]
    input  logic [srdm_pkg::DATA_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,

    // out_news_id [31:0], out_upd_kind [63:32], out_sequence [127:64],
    // out_timestamp [191:128]
    output logic [srdm_pkg::DATA_W-1:0] m_axis_tdata,
    // status [0]
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready
);
    import srdm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STORE,
        ST_REJECT,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [SEQ_W-1:0]        last_released_reg, last_released_next;
    logic [IDX_W-1:0]        head_idx_reg, head_idx_next;
    logic [WINDOW_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W:0]          ahead_reg, ahead_next;
    logic                    is_last_reg, is_last_next;

    logic [ID_W-1:0]         in_id_reg;
    logic [UT_W-1:0]         in_ut_reg;
    logic [SEQ_W-1:0]        in_seq_reg;
    logic [TS_W-1:0]         in_ts_reg;

    logic [DATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;
    logic                    m_tlast_reg, m_tlast_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    slot_t                   slot_mem [WINDOW_DEPTH];
    slot_t                   rd_data_reg;
    logic                    mem_we;
    logic                    mem_re;
    logic [IDX_W-1:0]        store_idx;
    logic [IDX_W:0]          store_sum;
    logic [IDX_W-1:0]        head_inc;

    logic [SEQ_W-1:0]        op_a;
    logic [SEQ_W-1:0]        op_b;
    alu_res_t                alu_res;

    logic                    s_accept;
    logic                    out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;
    assign m_axis_tlast  = m_tlast_reg;
    assign m_axis_tvalid = m_tvalid_reg;

    // check: seq - last_released; drain: last_released + 1
    assign op_a = (state_reg == ST_CHECK) ? in_seq_reg : last_released_reg;
    assign op_b = (state_reg == ST_CHECK) ? last_released_reg : SEQ_MAX;

    srdm_alu u_alu
    (
        .op_a (op_a),
        .op_b (op_b),
        .res  (alu_res)
    );

    // slot of the stored record: head + (ahead - 1), wrapped once
    assign store_sum = {1'b0, head_idx_reg} + (ahead_reg - {{IDX_W{1'b0}}, 1'b1});
    assign store_idx = (store_sum >= (IDX_W + 1)'(WINDOW_DEPTH))
                     ? IDX_W'(store_sum - (IDX_W + 1)'(WINDOW_DEPTH))
                     : IDX_W'(store_sum);
    assign head_inc  = (head_idx_reg == IDX_W'(WINDOW_DEPTH - 1))
                     ? '0 : head_idx_reg + IDX_W'(1);

    always_comb
    begin
        state_next         = state_reg;
        last_released_next = last_released_reg;
        head_idx_next      = head_idx_reg;
        slot_valid_next    = slot_valid_reg;
        count_next         = count_reg;
        ahead_next         = ahead_reg;
        is_last_next       = is_last_reg;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;
        m_tlast_next       = m_tlast_reg;
        m_tvalid_next      = m_tvalid_reg;
        mem_we             = 1'b0;
        mem_re             = 1'b0;

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // zero, old and repeated sequences are dropped
                if (in_seq_reg == '0 || !alu_res.no_borrow || alu_res.diff == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (alu_res.diff > SEQ_W'(WINDOW_DEPTH))
                begin
                    state_next = ST_REJECT;
                end
                else
                begin
                    ahead_next = alu_res.diff[IDX_W:0];
                    state_next = ST_STORE;
                end
            end
            ST_REJECT:
            begin
                if (out_free)
                begin
                    m_tdata_next  = {in_ts_reg, in_seq_reg, in_ut_reg, in_id_reg};
                    m_tuser_next  = STATUS_REJECTED;
                    m_tlast_next  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_STORE:
            begin
                if (slot_valid_reg[store_idx])
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_we                     = 1'b1;
                    slot_valid_next[store_idx] = 1'b1;
                    count_next                 = '0;
                    state_next                 = ST_READ;
                end
            end
            ST_READ:
            begin
                if (slot_valid_reg[head_idx_reg] && last_released_reg != SEQ_MAX)
                begin
                    mem_re       = 1'b1;
                    // decide last before the result goes out
                    is_last_next = !slot_valid_reg[head_inc]
                                || last_released_reg == SEQ_MAX - SEQ_W'(1)
                                || count_reg == CNT_W'(WINDOW_DEPTH - 1);
                    state_next   = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tdata_next  = {rd_data_reg.timestamp, alu_res.diff,
                                     rd_data_reg.upd_kind, rd_data_reg.news_id};
                    m_tuser_next  = STATUS_RELEASED;
                    m_tlast_next  = is_last_reg;
                    m_tvalid_next = 1'b1;
                    slot_valid_next[head_idx_reg] = 1'b0;
                    last_released_next = alu_res.diff;
                    head_idx_next      = head_inc;
                    count_next         = count_reg + CNT_W'(1);
                    state_next         = is_last_reg ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            last_released_reg <= '0;
            head_idx_reg      <= IDX_W'(1);
            slot_valid_reg    <= '0;
            count_reg         <= '0;
            ahead_reg         <= '0;
            is_last_reg       <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            last_released_reg <= last_released_next;
            head_idx_reg      <= head_idx_next;
            slot_valid_reg    <= slot_valid_next;
            count_reg         <= count_next;
            ahead_reg         <= ahead_next;
            is_last_reg       <= is_last_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_id_reg  <= s_axis_tdata[ID_W-1:0];
            in_ut_reg  <= s_axis_tdata[ID_W+UT_W-1:ID_W];
            in_seq_reg <= s_axis_tdata[ID_W+UT_W+SEQ_W-1:ID_W+UT_W];
            in_ts_reg  <= s_axis_tdata[DATA_W-1:ID_W+UT_W+SEQ_W];
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // reorder window storage, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[store_idx] <= '{timestamp: in_ts_reg,
                                     upd_kind:  in_ut_reg,
                                     news_id:   in_id_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[head_idx_reg];
        end
    end

endmodule

@@ tb/sequence_reorder_dedup_merge_checker.sv @@
// scoreboard for sequence_reorder_dedup_merge_top: predicts the in-order release
// stream from every accepted request and compares each result taken on m_axis
// depends on srdm_pkg
`timescale 1ns / 1ps

module sequence_reorder_dedup_merge_checker
(
    input  logic                        clk,
    input  logic                        rst_n,

    // news_id [31:0], upd_kind [63:32], sequence_req [127:64], timestamp [191:128]
    input  logic [srdm_pkg::DATA_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,

    // out_news_id [31:0], out_upd_kind [63:32], out_sequence [127:64],
    // out_timestamp [191:128]
    input  logic [srdm_pkg::DATA_W-1:0] m_axis_tdata,
    // status [0]
    input  logic                        m_axis_tuser,
    input  logic                        m_axis_tlast,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,

    output int                          pending,
    output int                          fail_count
);

    import srdm_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]  news_id;
        logic [UT_W-1:0]  upd_kind;
        logic [SEQ_W-1:0] seq_no;
        logic [TS_W-1:0]  stamp;
        logic             status;
        logic             last;
    } release_t;

    logic [SEQ_W-1:0] released_upto;
    logic             held [WINDOW_DEPTH];
    slot_t            held_rec [WINDOW_DEPTH];
    release_t         release_q [$];
    release_t         want;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, exp_val);
        fail_count++;
    endtask

    // window model: drop, reject or store the request, then release what follows
    task automatic predict_release(input slot_t rec, input logic [SEQ_W-1:0] seq_no);
        logic [SEQ_W-1:0] nxt;
        int               idx;
        int               n;
        n = 0;
        if (seq_no == '0 || seq_no <= released_upto)
            return;
        if (seq_no - released_upto > SEQ_W'(WINDOW_DEPTH))
        begin
            release_q.push_back('{rec.news_id, rec.upd_kind, seq_no, rec.timestamp,
                                  STATUS_REJECTED, 1'b1});
            return;
        end
        idx = int'(seq_no % SEQ_W'(WINDOW_DEPTH));
        if (held[idx])
            return;
        held[idx]     = 1'b1;
        held_rec[idx] = rec;
        while (released_upto != SEQ_MAX && n < WINDOW_DEPTH)
        begin
            nxt = released_upto + 1'b1;
            idx = int'(nxt % SEQ_W'(WINDOW_DEPTH));
            if (!held[idx])
                break;
            release_q.push_back('{held_rec[idx].news_id, held_rec[idx].upd_kind, nxt,
                                  held_rec[idx].timestamp, STATUS_RELEASED, 1'b0});
            held[idx]     = 1'b0;
            released_upto = nxt;
            n++;
        end
        if (n > 0)
            release_q[release_q.size()-1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            released_upto = '0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                held[i] = 1'b0;
            release_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_release(slot_t'({s_axis_tdata[191:128], s_axis_tdata[63:32],
                                         s_axis_tdata[31:0]}), s_axis_tdata[127:64]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (release_q.size() == 0)
                    report_mismatch("result with nothing pending, sequence",
                                    m_axis_tdata[127:64], '0);
                else
                begin
                    want = release_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.news_id)
                        report_mismatch("news_id", m_axis_tdata[31:0], want.news_id);
                    if (m_axis_tdata[63:32] !== want.upd_kind)
                        report_mismatch("upd_kind", m_axis_tdata[63:32], want.upd_kind);
                    if (m_axis_tdata[127:64] !== want.seq_no)
                        report_mismatch("sequence", m_axis_tdata[127:64], want.seq_no);
                    if (m_axis_tdata[191:128] !== want.stamp)
                        report_mismatch("timestamp", m_axis_tdata[191:128], want.stamp);
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                end
            end
            pending <= release_q.size();
        end
    end

endmodule

@@ tb/sequence_reorder_dedup_merge_top_tb.sv @@
// testbench top for sequence_reorder_dedup_merge_top: directed and two-feed random
// requests under several idle/stall phases, verdict from the checker's count
// depends on srdm_pkg, sequence_reorder_dedup_merge_top and the checker module
`timescale 1ns / 1ps

module sequence_reorder_dedup_merge_top_tb;

    import srdm_pkg::*;

    localparam int ITEM_TARGET   = 430;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int NOISE         = -1;

    localparam logic [UT_W-1:0] UPD_NEW     = 32'd1;
    localparam logic [UT_W-1:0] UPD_MODIFY  = 32'd2;
    localparam logic [UT_W-1:0] UPD_DISCARD = 32'd3;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;

    int               pending;
    int               fail_count;
    int               src_idle_pct   = 0;
    int               sink_stall_pct = 0;
    int               idle_cycles    = 0;
    int               records_sent;
    int               phase;
    int               cur_phase;
    int               span;
    int               roll;
    bit               hold_first;
    logic [SEQ_W-1:0] seq_base;

    sequence_reorder_dedup_merge_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    sequence_reorder_dedup_merge_checker order_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // no request or result moving for too long means the block is stuck
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("sequence_reorder_dedup_merge_top test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [UT_W-1:0] pick_upd_kind();
        if ($urandom_range(3) == 0)
            return UT_W'($urandom);
        return UT_W'($urandom_range(1, 3));
    endfunction

    task automatic push_record(input logic [ID_W-1:0] id, input logic [UT_W-1:0] ut,
                               input logic [SEQ_W-1:0] seq, input logic [TS_W-1:0] ts);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {ts, seq, ut, id};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        records_sent++;
    endtask

    // hold off the sender until every pending result has been taken
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one block of consecutive sequences as both feeds deliver it: shuffled,
    // partly repeated, with stray zero, stale and far-ahead requests mixed in
    task automatic run_burst(input int len, input bit gap_last);
        logic [ID_W-1:0]  ids [WINDOW_DEPTH];
        logic [UT_W-1:0]  uts [WINDOW_DEPTH];
        logic [TS_W-1:0]  tss [WINDOW_DEPTH];
        logic [SEQ_W-1:0] seq;
        int               order [$];
        int               k;
        int               j;
        int               tmp;
        for (k = 0; k < len; k++)
        begin
            ids[k] = $urandom;
            uts[k] = pick_upd_kind();
            tss[k] = {$urandom, $urandom};
            order.push_back(k);
        end
        for (k = len - 1; k > 0; k--)
        begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        // the lowest sequence arriving last releases the whole block at once
        if (gap_last)
        begin
            for (k = 0; k < order.size(); k++)
                if (order[k] == 0)
                    tmp = k;
            order.delete(tmp);
            order.push_back(0);
        end
        for (k = 0; k < len; k++)
            if (!(gap_last && k == 0) && $urandom_range(99) < 35)
                order.insert($urandom_range(order.size()), k);
        for (k = 0; k < len; k++)
            if ($urandom_range(99) < 12)
                order.insert($urandom_range(order.size()), NOISE);
        for (k = 0; k < order.size(); k++)
        begin
            if (order[k] == NOISE)
            begin
                case ($urandom_range(2))
                    0:       seq = '0;
                    1:       seq = 64'd1 + ({$urandom, $urandom} % seq_base);
                    default:
                        if ($urandom_range(1) == 0)
                            seq = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
                        else
                            seq = seq_base + SEQ_W'(len) + 64'd33 + $urandom_range(1000);
                endcase
                push_record($urandom, pick_upd_kind(), seq, {$urandom, $urandom});
            end
            else
                push_record(ids[order[k]], uts[order[k]], seq_base + 64'd1 + order[k],
                            tss[order[k]]);
        end
        seq_base = seq_base + SEQ_W'(len);
    endtask

    initial
    begin
        records_sent = 0;
        cur_phase    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        push_record('1, '1, 64'd0, '1);
        push_record('0, UPD_NEW, 64'd1, '0);
        push_record('1, UPD_MODIFY, 64'd3, '1);
        push_record(32'h0bad_cafe, UPD_NEW, 64'd3, 64'h1);
        push_record(32'ha5a5_a5a5, UPD_DISCARD, 64'd2, 64'h5a5a_5a5a_5a5a_5a5a);
        push_record(32'h1111_1111, UPD_NEW, 64'd1, 64'h2);
        push_record(32'h2222_2222, UPD_NEW, 64'd2, 64'h3);
        push_record(32'h3636_3636, UPD_MODIFY, 64'd36, 64'h36);
        push_record('1, '1, SEQ_MAX, '1);
        push_record(32'h8000_0000, UPD_NEW, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        push_record(32'h3535_3535, 32'd0, 64'd35, 64'hffff_0000_ffff_0000);
        push_record(32'h4444_4444, 32'd4, 64'd4, 64'h0000_ffff_0000_ffff);
        push_record(32'h6666_6666, '1, 64'd6, 64'h6666);
        push_record(32'h1234_5678, UPD_MODIFY, 64'd0, 64'h1234);
        push_record(32'h5555_5555, UPD_DISCARD, 64'd5, 64'h5555);
        seq_base = 64'd6;

        while (records_sent < ITEM_TARGET)
        begin
            phase = records_sent * 4 / ITEM_TARGET;
            if (phase != cur_phase)
            begin
                settle();
                cur_phase = phase;
                case (phase)
                    1:       begin src_idle_pct <= 87; sink_stall_pct <= 0;  end
                    2:       begin src_idle_pct <= 0;  sink_stall_pct <= 87; end
                    default: begin src_idle_pct <= 34; sink_stall_pct <= 34; end
                endcase
            end
            roll = $urandom_range(99);
            if (roll < 6)
            begin
                span       = WINDOW_DEPTH;
                hold_first = 1'b1;
            end
            else if (roll < 20)
            begin
                span       = $urandom_range(9, WINDOW_DEPTH);
                hold_first = $urandom_range(1);
            end
            else
            begin
                span       = $urandom_range(1, 8);
                hold_first = ($urandom_range(3) == 0);
            end
            run_burst(span, hold_first);
        end

        settle();
        if (fail_count == 0)
            $display("sequence_reorder_dedup_merge_top test passed");
        else
            $display("sequence_reorder_dedup_merge_top test failed");
        $finish;
    end

endmodule
